// File: design/trsmi_pkg.sv
// Package for the TRS matrix and inverse unit: transaction structs, product type,
// fixed-point constants and width-fixed helper functions.
// No dependencies.
`default_nettype none

package trsmi_pkg;

    // Default number of fractional bits of the Q format.
    localparam int FRAC_BITS_DEF = 16;

    // Result rows per transaction: four forward rows, then four inverse rows.
    localparam int NUM_ROWS = 8;

    // Signed element limits.
    localparam logic signed [65:0] SAT_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN_W = -66'sd2147483648;
    localparam logic signed [31:0] ELEM_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [31:0] ELEM_MIN  = 32'sh80000000;

    // Input transaction.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } in_t;

    // Result transaction: one matrix row.
    typedef struct packed {
        logic               which_matrix;
        logic [1:0]         row_index;
        logic signed [31:0] elem_c0;
        logic signed [31:0] elem_c1;
        logic signed [31:0] elem_c2;
        logic signed [31:0] elem_c3;
        logic               scale_zero;
        logic               last_row;
    } out_t;

    // Unrounded product held as sign and magnitude.
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } prod_t;

    // Full product of two signed operands of magnitude at most 2^31.
    function automatic prod_t fx_mul(input logic signed [32:0] a, input logic signed [32:0] b);
        prod_t       p;
        logic [31:0] ma;
        logic [31:0] mb;
        ma    = a[32] ? 32'(-a) : a[31:0];
        mb    = b[32] ? 32'(-b) : b[31:0];
        p.neg = a[32] ^ b[32];
        p.mag = {32'd0, ma} * {32'd0, mb};
        return p;
    endfunction

    // Saturate a wide signed value to the 32-bit element range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX_W) begin
            r = ELEM_MAX;
        end
        else if (v < SAT_MIN_W) begin
            r = ELEM_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Sign extension of an element by one bit.
    function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
        return $signed({v[31], v});
    endfunction

endpackage

`default_nettype wire

// File: design/trs_matrix_and_inverse_unit.sv
// Top level of the TRS matrix and inverse unit: reciprocal divider pipeline,
// matrix product pipeline and row sequencer. Depends on trsmi_pkg.
`default_nettype none

// Usage:
// A command transaction (translation, rotation quaternion, scale) is taken at a
// rising edge where start is high and busy is low. busy rises after each accepted
// command and stays high while the rate counter counts down from NUM_ROWS - 1,
// so a new command is not taken until the counter has reached zero.
// Each command yields eight result transactions on consecutive cycles, marked
// by strobe: forward rows 0..3, then inverse rows 0..3; last_row marks the
// eighth. The receiver cannot stall and every result is taken at the edge that
// ends its cycle.
// The first row reaches the result ports through the DW + 1 divider stages,
// where DW = max(2*FRAC_BITS+1, 32) is the quotient width of the
// one-bit-per-stage reciprocal divider, eight matrix stages (reciprocal finish,
// quaternion products, rounding, rotation, scale products, rounding and
// saturation, dot products, inverse translation) and the row buffer.
// Several commands are in flight in the pipeline at once.
// Reset clears all valid bits, the row sequencer and the rate counter; no
// result is issued until a command has passed the whole pipeline.
module trs_matrix_and_inverse_unit #(
    parameter int FRAC_BITS = trsmi_pkg::FRAC_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  trsmi_pkg::in_t       cmd,
    output logic                 busy,
    output logic                 strobe,
    output trsmi_pkg::out_t      result
);

    localparam int DW = (2 * FRAC_BITS + 1 > 32) ? 2 * FRAC_BITS + 1 : 32;
    localparam int GW = $clog2(trsmi_pkg::NUM_ROWS);
    localparam logic signed [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [65:0] ONE_W  = 66'(66'd1 << FRAC_BITS);
    localparam logic [63:0]        HALF   = 64'd1 << (FRAC_BITS - 1);
    localparam logic [DW-1:0]      DVD_HI = DW'(1) << (2 * FRAC_BITS);

    // Indexes of the quaternion products.
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_XW = 6;
    localparam int P_YW = 7;
    localparam int P_ZW = 8;

    // Round to nearest, halves away from zero, and restore the sign.
    function automatic logic signed [65:0] fx_round(input trsmi_pkg::prod_t p);
        logic [63:0]        rm;
        logic signed [65:0] v;
        rm = (p.mag + HALF) >> FRAC_BITS;
        v  = $signed({2'b00, rm});
        return p.neg ? -v : v;
    endfunction

    // ------------------------------------------------------------------
    // Rate counter: spaces accepted commands by holding busy high.
    // ------------------------------------------------------------------
    logic          accept;
    logic [GW-1:0] gap_reg;
    logic [GW-1:0] gap_next;

    assign accept = start & ~busy;
    assign busy   = (gap_reg != '0);

    always_comb
    begin
        if (accept) begin
            gap_next = GW'(trsmi_pkg::NUM_ROWS - 1);
        end
        else if (gap_reg != '0) begin
            gap_next = gap_reg - 1'b1;
        end
        else begin
            gap_next = gap_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gap_reg <= '0;
        end
        else begin
            gap_reg <= gap_next;
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal divider: three lanes, one quotient bit per stage.
    // ------------------------------------------------------------------
    logic signed [31:0] cmd_scale [3];
    logic [31:0]        cmd_mag   [3];
    logic [31:0]        dv_rem_reg [3][DW+1];
    logic [DW-1:0]      dv_q_reg   [3][DW+1];
    logic [31:0]        dv_m_reg   [3][DW+1];
    logic [DW-1:0]      dv_d_reg   [3][DW+1];
    trsmi_pkg::in_t     dv_item_reg [DW+1];
    logic               dv_vld_reg  [DW+1];
    logic [32:0]        dv_trial [3][DW];
    logic               dv_ge    [3][DW];

    always_comb
    begin
        cmd_scale[0] = cmd.scale_x;
        cmd_scale[1] = cmd.scale_y;
        cmd_scale[2] = cmd.scale_z;
        for (int l = 0; l < 3; l++) begin
            cmd_mag[l] = cmd_scale[l][31] ? 32'(-cmd_scale[l]) : cmd_scale[l];
        end
    end

    // Shift in one dividend bit per stage and subtract where it fits.
    always_comb
    begin
        for (int l = 0; l < 3; l++) begin
            for (int k = 0; k < DW; k++) begin
                dv_trial[l][k] = {dv_rem_reg[l][k], dv_d_reg[l][k][DW-1-k]};
                dv_ge[l][k]    = (dv_trial[l][k] >= {1'b0, dv_m_reg[l][k]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_item_reg[0] <= cmd;
        for (int l = 0; l < 3; l++) begin
            dv_rem_reg[l][0] <= '0;
            dv_q_reg[l][0]   <= '0;
            dv_m_reg[l][0]   <= cmd_mag[l];
            dv_d_reg[l][0]   <= DVD_HI + DW'(cmd_mag[l] >> 1);
        end
        for (int k = 0; k < DW; k++) begin
            dv_item_reg[k+1] <= dv_item_reg[k];
            for (int l = 0; l < 3; l++) begin
                dv_rem_reg[l][k+1] <= dv_ge[l][k]
                    ? 32'(dv_trial[l][k] - {1'b0, dv_m_reg[l][k]})
                    : dv_trial[l][k][31:0];
                dv_q_reg[l][k+1] <= dv_q_reg[l][k]
                    | (dv_ge[l][k] ? (DW'(1) << (DW - 1 - k)) : DW'(0));
                dv_m_reg[l][k+1] <= dv_m_reg[l][k];
                dv_d_reg[l][k+1] <= dv_d_reg[l][k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal finish: saturation, sign and zero scale.
    // ------------------------------------------------------------------
    logic signed [31:0] dv_scale [3];
    logic signed [31:0] rc_next  [3];
    logic               rc_zero_next;
    logic               rc_vld_reg;
    trsmi_pkg::in_t     rc_item_reg;
    logic signed [31:0] rc_r_reg [3];
    logic               rc_zero_reg;

    always_comb
    begin
        logic [30:0] qm;
        dv_scale[0]  = dv_item_reg[DW].scale_x;
        dv_scale[1]  = dv_item_reg[DW].scale_y;
        dv_scale[2]  = dv_item_reg[DW].scale_z;
        rc_zero_next = 1'b0;
        for (int l = 0; l < 3; l++) begin
            qm = (dv_q_reg[l][DW][DW-1:31] != '0) ? 31'h7FFFFFFF : dv_q_reg[l][DW][30:0];
            if (dv_scale[l] == '0) begin
                rc_next[l]   = trsmi_pkg::ELEM_MAX;
                rc_zero_next = 1'b1;
            end
            else if (dv_scale[l][31]) begin
                rc_next[l] = -$signed({1'b0, qm});
            end
            else begin
                rc_next[l] = $signed({1'b0, qm});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rc_item_reg <= dv_item_reg[DW];
        rc_r_reg    <= rc_next;
        rc_zero_reg <= rc_zero_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: quaternion products.
    // ------------------------------------------------------------------
    trsmi_pkg::prod_t   qp_prod_reg [9];
    trsmi_pkg::in_t     qp_item_reg;
    logic signed [31:0] qp_r_reg [3];
    logic               qp_zero_reg;
    logic               qp_vld_reg;

    always_ff @(posedge clk)
    begin
        qp_prod_reg[P_XX] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_x),
                                               trsmi_pkg::ext33(rc_item_reg.quat_x));
        qp_prod_reg[P_YY] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_y),
                                               trsmi_pkg::ext33(rc_item_reg.quat_y));
        qp_prod_reg[P_ZZ] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_z),
                                               trsmi_pkg::ext33(rc_item_reg.quat_z));
        qp_prod_reg[P_XY] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_x),
                                               trsmi_pkg::ext33(rc_item_reg.quat_y));
        qp_prod_reg[P_XZ] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_x),
                                               trsmi_pkg::ext33(rc_item_reg.quat_z));
        qp_prod_reg[P_YZ] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_y),
                                               trsmi_pkg::ext33(rc_item_reg.quat_z));
        qp_prod_reg[P_XW] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_x),
                                               trsmi_pkg::ext33(rc_item_reg.quat_w));
        qp_prod_reg[P_YW] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_y),
                                               trsmi_pkg::ext33(rc_item_reg.quat_w));
        qp_prod_reg[P_ZW] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rc_item_reg.quat_z),
                                               trsmi_pkg::ext33(rc_item_reg.quat_w));
        qp_item_reg <= rc_item_reg;
        qp_r_reg    <= rc_r_reg;
        qp_zero_reg <= rc_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: rounding of the quaternion products.
    // ------------------------------------------------------------------
    logic signed [65:0] qr_val_reg [9];
    trsmi_pkg::in_t     qr_item_reg;
    logic signed [31:0] qr_r_reg [3];
    logic               qr_zero_reg;
    logic               qr_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 9; n++) begin
            qr_val_reg[n] <= fx_round(qp_prod_reg[n]);
        end
        qr_item_reg <= qp_item_reg;
        qr_r_reg    <= qp_r_reg;
        qr_zero_reg <= qp_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: rotation matrix elements.
    // ------------------------------------------------------------------
    logic signed [31:0] rm_next [3][3];
    logic signed [31:0] rm_reg  [3][3];
    trsmi_pkg::in_t     rm_item_reg;
    logic signed [31:0] rm_r_reg [3];
    logic               rm_zero_reg;
    logic               rm_vld_reg;

    always_comb
    begin
        rm_next[0][0] = trsmi_pkg::sat32(ONE_W - ((qr_val_reg[P_YY] + qr_val_reg[P_ZZ]) <<< 1));
        rm_next[0][1] = trsmi_pkg::sat32((qr_val_reg[P_XY] - qr_val_reg[P_ZW]) <<< 1);
        rm_next[0][2] = trsmi_pkg::sat32((qr_val_reg[P_XZ] + qr_val_reg[P_YW]) <<< 1);
        rm_next[1][0] = trsmi_pkg::sat32((qr_val_reg[P_XY] + qr_val_reg[P_ZW]) <<< 1);
        rm_next[1][1] = trsmi_pkg::sat32(ONE_W - ((qr_val_reg[P_XX] + qr_val_reg[P_ZZ]) <<< 1));
        rm_next[1][2] = trsmi_pkg::sat32((qr_val_reg[P_YZ] - qr_val_reg[P_XW]) <<< 1);
        rm_next[2][0] = trsmi_pkg::sat32((qr_val_reg[P_XZ] - qr_val_reg[P_YW]) <<< 1);
        rm_next[2][1] = trsmi_pkg::sat32((qr_val_reg[P_YZ] + qr_val_reg[P_XW]) <<< 1);
        rm_next[2][2] = trsmi_pkg::sat32(ONE_W - ((qr_val_reg[P_XX] + qr_val_reg[P_YY]) <<< 1));
    end

    always_ff @(posedge clk)
    begin
        rm_reg      <= rm_next;
        rm_item_reg <= qr_item_reg;
        rm_r_reg    <= qr_r_reg;
        rm_zero_reg <= qr_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: scale, translation and reciprocal products.
    // ------------------------------------------------------------------
    logic signed [31:0] rm_s [3];
    logic signed [31:0] rm_p [3];
    trsmi_pkg::prod_t   mp_fwd_reg [3][3];
    trsmi_pkg::prod_t   mp_acc_reg [3][3];
    trsmi_pkg::prod_t   mp_inv_reg [3][3];
    logic signed [31:0] mp_p_reg [3];
    logic signed [31:0] mp_r_reg [3];
    logic               mp_zero_reg;
    logic               mp_vld_reg;

    always_comb
    begin
        rm_s[0] = rm_item_reg.scale_x;
        rm_s[1] = rm_item_reg.scale_y;
        rm_s[2] = rm_item_reg.scale_z;
        rm_p[0] = rm_item_reg.pos_x;
        rm_p[1] = rm_item_reg.pos_y;
        rm_p[2] = rm_item_reg.pos_z;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mp_fwd_reg[i][j] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rm_reg[i][j]),
                                                      trsmi_pkg::ext33(rm_s[j]));
                mp_acc_reg[i][j] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rm_reg[j][i]),
                                                      trsmi_pkg::ext33(rm_p[j]));
                mp_inv_reg[i][j] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(rm_r_reg[i]),
                                                      trsmi_pkg::ext33(rm_reg[j][i]));
            end
        end
        mp_p_reg    <= rm_p;
        mp_r_reg    <= rm_r_reg;
        mp_zero_reg <= rm_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: rounding and saturation of the rotation products.
    // ------------------------------------------------------------------
    logic signed [31:0] ms_fwd_reg [3][3];
    logic signed [31:0] ms_inv_reg [3][3];
    logic signed [65:0] ms_acc_reg [3][3];
    logic signed [31:0] ms_p_reg [3];
    logic signed [31:0] ms_r_reg [3];
    logic               ms_zero_reg;
    logic               ms_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ms_fwd_reg[i][j] <= trsmi_pkg::sat32(fx_round(mp_fwd_reg[i][j]));
                ms_inv_reg[i][j] <= trsmi_pkg::sat32(fx_round(mp_inv_reg[i][j]));
                ms_acc_reg[i][j] <= fx_round(mp_acc_reg[i][j]);
            end
        end
        ms_p_reg    <= mp_p_reg;
        ms_r_reg    <= mp_r_reg;
        ms_zero_reg <= mp_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: dot products, saturated and negated.
    // ------------------------------------------------------------------
    logic signed [32:0] na_reg [3];
    logic signed [31:0] na_fwd_reg [3][3];
    logic signed [31:0] na_inv_reg [3][3];
    logic signed [31:0] na_p_reg [3];
    logic signed [31:0] na_r_reg [3];
    logic               na_zero_reg;
    logic               na_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            na_reg[i] <= -trsmi_pkg::ext33(trsmi_pkg::sat32(
                ms_acc_reg[i][0] + ms_acc_reg[i][1] + ms_acc_reg[i][2]));
        end
        na_fwd_reg  <= ms_fwd_reg;
        na_inv_reg  <= ms_inv_reg;
        na_p_reg    <= ms_p_reg;
        na_r_reg    <= ms_r_reg;
        na_zero_reg <= ms_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: inverse translation products.
    // ------------------------------------------------------------------
    trsmi_pkg::prod_t   np_prod_reg [3];
    logic signed [31:0] np_fwd_reg [3][3];
    logic signed [31:0] np_inv_reg [3][3];
    logic signed [31:0] np_p_reg [3];
    logic               np_zero_reg;
    logic               np_vld_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            np_prod_reg[i] <= trsmi_pkg::fx_mul(trsmi_pkg::ext33(na_r_reg[i]), na_reg[i]);
        end
        np_fwd_reg  <= na_fwd_reg;
        np_inv_reg  <= na_inv_reg;
        np_p_reg    <= na_p_reg;
        np_zero_reg <= na_zero_reg;
    end

    // ------------------------------------------------------------------
    // Stage 8: row buffer, loaded with the finished matrices.
    // ------------------------------------------------------------------
    logic signed [31:0] ob_fwd_reg [3][3];
    logic signed [31:0] ob_inv_reg [3][3];
    logic signed [31:0] ob_p_reg [3];
    logic signed [31:0] ob_t_reg [3];
    logic               ob_zero_reg;

    always_ff @(posedge clk)
    begin
        if (np_vld_reg) begin
            for (int i = 0; i < 3; i++) begin
                ob_t_reg[i] <= trsmi_pkg::sat32(fx_round(np_prod_reg[i]));
            end
            ob_fwd_reg  <= np_fwd_reg;
            ob_inv_reg  <= np_inv_reg;
            ob_p_reg    <= np_p_reg;
            ob_zero_reg <= np_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of all stages and the row sequencer.
    // ------------------------------------------------------------------
    logic          act_reg;
    logic          act_next;
    logic [GW-1:0] cnt_reg;
    logic [GW-1:0] cnt_next;

    always_comb
    begin
        if (np_vld_reg) begin
            act_next = 1'b1;
            cnt_next = '0;
        end
        else if (act_reg) begin
            act_next = (cnt_reg != GW'(trsmi_pkg::NUM_ROWS - 1));
            cnt_next = cnt_reg + 1'b1;
        end
        else begin
            act_next = 1'b0;
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
            rc_vld_reg <= 1'b0;
            qp_vld_reg <= 1'b0;
            qr_vld_reg <= 1'b0;
            rm_vld_reg <= 1'b0;
            mp_vld_reg <= 1'b0;
            ms_vld_reg <= 1'b0;
            na_vld_reg <= 1'b0;
            np_vld_reg <= 1'b0;
            act_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else begin
            dv_vld_reg[0] <= accept;
            for (int k = 0; k < DW; k++) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
            rc_vld_reg <= dv_vld_reg[DW];
            qp_vld_reg <= rc_vld_reg;
            qr_vld_reg <= qp_vld_reg;
            rm_vld_reg <= qr_vld_reg;
            mp_vld_reg <= rm_vld_reg;
            ms_vld_reg <= mp_vld_reg;
            na_vld_reg <= ms_vld_reg;
            np_vld_reg <= na_vld_reg;
            act_reg    <= act_next;
            cnt_reg    <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result transaction: select the row given by the sequencer.
    // ------------------------------------------------------------------
    logic [1:0] row;
    logic       inv_sel;

    assign row     = cnt_reg[1:0];
    assign inv_sel = cnt_reg[2];
    assign strobe  = act_reg;

    always_comb
    begin
        result.which_matrix = inv_sel;
        result.row_index    = row;
        result.scale_zero   = ob_zero_reg;
        result.last_row     = (cnt_reg == GW'(trsmi_pkg::NUM_ROWS - 1));
        if (row == 2'd3) begin
            // Homogeneous row of both matrices.
            result.elem_c0 = '0;
            result.elem_c1 = '0;
            result.elem_c2 = '0;
            result.elem_c3 = ONE_Q;
        end
        else if (!inv_sel) begin
            result.elem_c0 = ob_fwd_reg[row][0];
            result.elem_c1 = ob_fwd_reg[row][1];
            result.elem_c2 = ob_fwd_reg[row][2];
            result.elem_c3 = ob_p_reg[row];
        end
        else begin
            result.elem_c0 = ob_inv_reg[row][0];
            result.elem_c1 = ob_inv_reg[row][1];
            result.elem_c2 = ob_inv_reg[row][2];
            result.elem_c3 = ob_t_reg[row];
        end
    end

endmodule

`default_nettype wire
